// ===== hw/rtl/rcf_pkg.sv =====
`default_nettype none

package rcf_pkg;

  localparam int DISTANCE_BITS_DEFAULT = 19;
  localparam int QUALITY_BITS          = 16;
  localparam int COUNT_BITS            = 8;
  localparam int CFG_INDEX_BITS        = 3;

  // Reset values before truncation to the distance width.
  localparam logic [31:0] MAX_PLAUSIBLE_RESET = 32'd200000;
  localparam logic [31:0] MAX_SPREAD_RESET    = 32'd100;
  localparam logic [COUNT_BITS-1:0] CONSENSUS_RESET = 8'd3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MIN_PLAUSIBLE = 3'd0,
    REG_MAX_PLAUSIBLE = 3'd1,
    REG_MIN_QUALITY   = 3'd2,
    REG_CONSENSUS     = 3'd3,
    REG_MAX_SPREAD    = 3'd4
  } cfg_reg_t;

  // Streak and trust state carried between consecutive measurements.
  typedef struct packed {
    logic                           prev_valid;
    logic [COUNT_BITS-1:0]          agree_count;
    logic [COUNT_BITS-1:0]          pass_count;
    logic signed [QUALITY_BITS-1:0] lowest_quality;
    logic                           trust_flag;
  } streak_t;

  // Status flags of one result beat.
  typedef struct packed {
    logic plausible;
    logic quality_passed;
  } flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcf_core.sv =====
`default_nettype none

module rcf_core #(
  parameter int DISTANCE_BITS = rcf_pkg::DISTANCE_BITS_DEFAULT
) (
  input  wire logic                                   op,
  input  wire logic signed [DISTANCE_BITS-1:0]        distance_mm,
  input  wire logic                                   verdict_ok,
  input  wire logic signed [rcf_pkg::QUALITY_BITS-1:0] sts_quality,
  input  wire logic signed [DISTANCE_BITS-1:0]        min_plausible_mm,
  input  wire logic signed [DISTANCE_BITS-1:0]        max_plausible_mm,
  input  wire logic signed [rcf_pkg::QUALITY_BITS-1:0] min_quality,
  input  wire logic [rcf_pkg::COUNT_BITS-1:0]         consensus_count,
  input  wire logic [DISTANCE_BITS-1:0]               max_spread_mm,
  input  wire logic signed [DISTANCE_BITS-1:0]        prev_distance,
  input  wire rcf_pkg::streak_t                       streak,
  output logic signed [DISTANCE_BITS-1:0]             prev_distance_next,
  output rcf_pkg::streak_t                            streak_next,
  output logic signed [DISTANCE_BITS-1:0]             distance_res,
  output logic signed [rcf_pkg::QUALITY_BITS-1:0]     quality_res,
  output rcf_pkg::flags_t                             flags_res
);
  import rcf_pkg::*;

  logic                            plaus;
  logic                            passed;
  logic signed [DISTANCE_BITS-1:0] dist_c;
  logic signed [DISTANCE_BITS:0]   diff;
  logic signed [DISTANCE_BITS:0]   adiff;
  logic                            agree;
  streak_t                         upd;

  assign plaus  = (distance_mm >= min_plausible_mm) && (distance_mm <= max_plausible_mm);
  assign dist_c = distance_mm[DISTANCE_BITS-1] ? '0 : distance_mm;
  assign passed = verdict_ok && (sts_quality >= min_quality);

  assign diff  = {dist_c[DISTANCE_BITS-1], dist_c} -
                 {prev_distance[DISTANCE_BITS-1], prev_distance};
  assign adiff = diff[DISTANCE_BITS] ? -diff : diff;
  assign agree = adiff[DISTANCE_BITS-1:0] <= max_spread_mm;

  always_comb begin
    upd = streak;
    if (passed) begin
      if (streak.pass_count == '0 || sts_quality < streak.lowest_quality) begin
        upd.lowest_quality = sts_quality;
      end
      if (streak.pass_count < consensus_count) begin
        upd.pass_count = streak.pass_count + 1'b1;
      end
    end else begin
      upd.pass_count     = '0;
      upd.lowest_quality = sts_quality;
    end
    if (streak.prev_valid && agree) begin
      if (streak.agree_count < consensus_count) begin
        upd.agree_count = streak.agree_count + 1'b1;
      end
    end else begin
      upd.agree_count = COUNT_BITS'(1);
    end
    upd.prev_valid = 1'b1;
    upd.trust_flag = upd.agree_count >= consensus_count;
  end

  always_comb begin
    priority if (op) begin
      prev_distance_next = '0;
      streak_next        = '0;
      distance_res       = '0;
      quality_res        = '0;
      flags_res          = '0;
    end else if (!plaus) begin
      prev_distance_next = '0;
      streak_next        = '0;
      distance_res       = distance_mm;
      quality_res        = sts_quality;
      flags_res          = '0;
    end else begin
      prev_distance_next       = dist_c;
      streak_next              = upd;
      distance_res             = dist_c;
      quality_res              = sts_quality;
      flags_res.plausible      = 1'b1;
      flags_res.quality_passed = passed;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/range_consensus_filter.sv =====
// range_consensus_filter: plausibility and streak filter for ranging readings.
// Input channel (in_valid/in_ready) carries one beat per measurement: op,
// distance_mm, verdict_ok, sts_quality. op = 1 clears all filter state and
// returns an all-zero result. Output channel (out_valid/out_ready) carries one
// result beat per input beat, in order.
// Each result beat passes through the input register, then the result
// register, before out_valid rises. Throughput: one beat per cycle while
// out_ready stays high, set by the single pass of compare/subtract logic
// between the two registers. When the receiver stalls, the result register
// holds its beat and the input register takes one more beat; in_ready drops
// only when both are full.
// Configuration: cfg_we writes cfg_data into the register named by cfg_index
// (0 min_plausible_mm, 1 max_plausible_mm, 2 min_quality, 3 consensus_count,
// 4 max_spread_mm); write only while the block is idle.
// Reset (rst, synchronous): configuration returns to its defaults, all streak
// state clears and both pipeline registers empty.
`default_nettype none

module range_consensus_filter #(
  parameter int DISTANCE_BITS = rcf_pkg::DISTANCE_BITS_DEFAULT
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_we,
  input  wire logic [rcf_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  wire logic [(DISTANCE_BITS > rcf_pkg::QUALITY_BITS ? DISTANCE_BITS
                      : rcf_pkg::QUALITY_BITS)-1:0]     cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic                                    op,
  input  wire logic signed [DISTANCE_BITS-1:0]         distance_mm,
  input  wire logic                                    verdict_ok,
  input  wire logic signed [rcf_pkg::QUALITY_BITS-1:0] sts_quality,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [DISTANCE_BITS-1:0]              distance_out,
  output logic signed [rcf_pkg::QUALITY_BITS-1:0]      quality_echo,
  output logic                                         plausible,
  output logic                                         quality_passed,
  output logic [rcf_pkg::COUNT_BITS-1:0]               quality_streak,
  output logic [rcf_pkg::COUNT_BITS-1:0]               agree_streak_out,
  output logic                                         trusted,
  output logic signed [rcf_pkg::QUALITY_BITS-1:0]      lowest_quality_out
);
  import rcf_pkg::*;

  // Configuration registers.
  logic signed [DISTANCE_BITS-1:0] min_plausible_mm;
  logic signed [DISTANCE_BITS-1:0] max_plausible_mm;
  logic signed [QUALITY_BITS-1:0]  min_quality;
  logic [COUNT_BITS-1:0]           consensus_count;
  logic [DISTANCE_BITS-1:0]        max_spread_mm;

  // Input register.
  logic                            s1_valid;
  logic                            s1_op;
  logic signed [DISTANCE_BITS-1:0] s1_distance;
  logic                            s1_verdict;
  logic signed [QUALITY_BITS-1:0]  s1_quality;

  // Filter state.
  logic signed [DISTANCE_BITS-1:0] prev_distance;
  streak_t                         streak;

  // Core results.
  logic signed [DISTANCE_BITS-1:0] prev_distance_next;
  streak_t                         streak_next;
  logic signed [DISTANCE_BITS-1:0] distance_res;
  logic signed [QUALITY_BITS-1:0]  quality_res;
  flags_t                          flags_res;

  logic s1_advance;

  // Advance the input beat whenever the result register is empty or draining.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_plausible_mm <= '0;
      max_plausible_mm <= MAX_PLAUSIBLE_RESET[DISTANCE_BITS-1:0];
      min_quality      <= '0;
      consensus_count  <= CONSENSUS_RESET;
      max_spread_mm    <= MAX_SPREAD_RESET[DISTANCE_BITS-1:0];
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_PLAUSIBLE: min_plausible_mm <= cfg_data[DISTANCE_BITS-1:0];
        REG_MAX_PLAUSIBLE: max_plausible_mm <= cfg_data[DISTANCE_BITS-1:0];
        REG_MIN_QUALITY:   min_quality      <= cfg_data[QUALITY_BITS-1:0];
        REG_CONSENSUS:     consensus_count  <= cfg_data[COUNT_BITS-1:0];
        REG_MAX_SPREAD:    max_spread_mm    <= cfg_data[DISTANCE_BITS-1:0];
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  // Input register: take a beat while empty or when the previous one moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_op       <= op;
      s1_distance <= distance_mm;
      s1_verdict  <= verdict_ok;
      s1_quality  <= sts_quality;
    end
  end

  rcf_core #(
    .DISTANCE_BITS(DISTANCE_BITS)
  ) u_core (
    .op                 (s1_op),
    .distance_mm        (s1_distance),
    .verdict_ok         (s1_verdict),
    .sts_quality        (s1_quality),
    .min_plausible_mm   (min_plausible_mm),
    .max_plausible_mm   (max_plausible_mm),
    .min_quality        (min_quality),
    .consensus_count    (consensus_count),
    .max_spread_mm      (max_spread_mm),
    .prev_distance      (prev_distance),
    .streak             (streak),
    .prev_distance_next (prev_distance_next),
    .streak_next        (streak_next),
    .distance_res       (distance_res),
    .quality_res        (quality_res),
    .flags_res          (flags_res)
  );

  // State and result register update together, once per advanced beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_distance <= '0;
      streak        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (s1_advance) begin
        prev_distance <= prev_distance_next;
        streak        <= streak_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_advance) begin
      distance_out       <= distance_res;
      quality_echo       <= quality_res;
      plausible          <= flags_res.plausible;
      quality_passed     <= flags_res.quality_passed;
      quality_streak     <= streak_next.pass_count;
      agree_streak_out   <= streak_next.agree_count;
      trusted            <= streak_next.trust_flag;
      lowest_quality_out <= streak_next.lowest_quality;
    end
  end

  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("in_ready low while pipeline has room");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

  a_trusted_is_plausible: assert property (@(posedge clk) disable iff (rst)
    (out_valid && trusted) |-> plausible)
    else $error("trusted result for an implausible beat");

  a_implausible_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !plausible) |-> (quality_streak == '0 && agree_streak_out == '0))
    else $error("streaks not cleared on implausible beat");

  a_plausible_agrees: assert property (@(posedge clk) disable iff (rst)
    (out_valid && plausible) |-> (agree_streak_out != '0))
    else $error("agreement streak zero on plausible beat");

endmodule

`default_nettype wire

// ===== sim/tb_range_consensus_filter.sv =====
module tb_range_consensus_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import rcf_pkg::*;

  localparam int DW = DISTANCE_BITS_DEFAULT;
  localparam int QW = QUALITY_BITS;
  localparam int CW = COUNT_BITS;

  // Operation codes carried on the op input.
  localparam logic OP_INGEST = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam int MM_LO = -(1 << (DW - 1));
  localparam int MM_HI = (1 << (DW - 1)) - 1;
  localparam int Q_LO  = -(1 << (QW - 1));
  localparam int Q_HI  = (1 << (QW - 1)) - 1;

  localparam int RANDOM_READINGS = 1550;
  localparam int QUIET_TAIL      = 150;
  localparam int STUCK_LIMIT     = 2000;

  // One measurement beat as offered on the input channel.
  typedef struct {
    logic                 op;
    logic signed [DW-1:0] mm;
    logic                 ok;
    logic signed [QW-1:0] qual;
  } reading_t;

  // One result beat, field for field as it leaves the block.
  typedef struct {
    logic signed [DW-1:0] mm;
    logic signed [QW-1:0] qual;
    logic                 plaus;
    logic                 qpass;
    logic [CW-1:0]        qrun;
    logic [CW-1:0]        arun;
    logic                 trusted;
    logic signed [QW-1:0] lowq;
  } filtered_t;

  // A row of the directed script: either a register write or a reading, the
  // latter optionally carrying a result worked out by hand.
  typedef struct {
    bit        is_cfg;
    cfg_reg_t  idx;
    int        val;
    reading_t  rd;
    bit        known;
    filtered_t want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [DW-1:0]        cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 op;
  logic signed [DW-1:0] distance_mm;
  logic                 verdict_ok;
  logic signed [QW-1:0] sts_quality;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [DW-1:0] distance_out;
  logic signed [QW-1:0] quality_echo;
  logic                 plausible;
  logic                 quality_passed;
  logic [CW-1:0]        quality_streak;
  logic [CW-1:0]        agree_streak_out;
  logic                 trusted;
  logic signed [QW-1:0] lowest_quality_out;

  range_consensus_filter #(.DISTANCE_BITS(DW)) dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .op                 (op),
    .distance_mm        (distance_mm),
    .verdict_ok         (verdict_ok),
    .sts_quality        (sts_quality),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .distance_out       (distance_out),
    .quality_echo       (quality_echo),
    .plausible          (plausible),
    .quality_passed     (quality_passed),
    .quality_streak     (quality_streak),
    .agree_streak_out   (agree_streak_out),
    .trusted            (trusted),
    .lowest_quality_out (lowest_quality_out)
  );

  always #4 clk = ~clk;

  // Shadow of the configuration registers, kept in step with every write.
  logic signed [DW-1:0] window_lo_mm;
  logic signed [DW-1:0] window_hi_mm;
  logic signed [QW-1:0] quality_floor;
  logic [CW-1:0]        consensus_need;
  logic [DW-1:0]        spread_limit_mm;

  // Filter state as the block should hold it after each accepted reading.
  int                   last_kept_mm;
  bit                   last_kept_ok;
  logic [CW-1:0]        agree_run;
  logic [CW-1:0]        pass_run;
  logic signed [QW-1:0] run_low_quality;
  bit                   trust_now;

  // Results owed by the block, oldest first.
  filtered_t   owed_results[$];
  script_row_t script[$];

  int  mismatches = 0;
  int  stuck_cycles = 0;
  int  stall_left = 0;
  int  gap_pct = 20;
  int  stall_pct = 20;
  bit  quiet = 1'b0;

  function automatic void clear_filter();
    last_kept_mm    = 0;
    last_kept_ok    = 1'b0;
    agree_run       = '0;
    pass_run        = '0;
    run_low_quality = '0;
    trust_now       = 1'b0;
  endfunction

  // Advance the filter state by one reading and return the result it owes.
  function automatic filtered_t predict_reading(reading_t r);
    filtered_t f;
    int        kept;
    int        gap;
    bit        qok;
    f = '{default: '0};
    if (r.op == OP_CLEAR) begin
      clear_filter();
      return f;
    end
    f.mm   = r.mm;
    f.qual = r.qual;
    // Outside the window: wipe everything, echo raw distance and quality.
    if (r.mm < window_lo_mm || r.mm > window_hi_mm) begin
      clear_filter();
      return f;
    end
    kept = r.mm;
    if (kept < 0) kept = 0;

    qok = r.ok && (r.qual >= quality_floor);
    if (qok) begin
      if (pass_run == 0 || r.qual < run_low_quality) run_low_quality = r.qual;
      if (pass_run < consensus_need) pass_run = pass_run + 1'b1;
    end else begin
      pass_run        = '0;
      run_low_quality = r.qual;
    end

    // Both distances are non-negative here, so int never overflows.
    if (last_kept_ok) begin
      gap = kept - last_kept_mm;
      if (gap < 0) gap = -gap;
      if (gap <= int'(spread_limit_mm)) begin
        if (agree_run < consensus_need) agree_run = agree_run + 1'b1;
      end else begin
        agree_run = CW'(1);
      end
    end else begin
      agree_run = CW'(1);
    end

    last_kept_mm = kept;
    last_kept_ok = 1'b1;
    trust_now    = (agree_run >= consensus_need);

    f.mm      = DW'(kept);
    f.plaus   = 1'b1;
    f.qpass   = qok;
    f.qrun    = pass_run;
    f.arun    = agree_run;
    f.trusted = trust_now;
    f.lowq    = run_low_quality;
    return f;
  endfunction

  function automatic int fit_mm(int v);
    if (v < MM_LO) return MM_LO;
    if (v > MM_HI) return MM_HI;
    return v;
  endfunction

  function automatic int fit_q(int v);
    if (v < Q_LO) return Q_LO;
    if (v > Q_HI) return Q_HI;
    return v;
  endfunction

  function automatic int rand_mm();
    logic signed [DW-1:0] x;
    x = DW'($urandom());
    return x;
  endfunction

  function automatic int rand_q();
    logic signed [QW-1:0] x;
    x = QW'($urandom());
    return x;
  endfunction

  function automatic filtered_t mk_out(int mm, int q, bit pl, bit qp, int qr, int ar,
                                       bit tr, int lq);
    filtered_t f;
    f.mm      = DW'(mm);
    f.qual    = QW'(q);
    f.plaus   = pl;
    f.qpass   = qp;
    f.qrun    = CW'(qr);
    f.arun    = CW'(ar);
    f.trusted = tr;
    f.lowq    = QW'(lq);
    return f;
  endfunction

  function automatic void add_cfg(cfg_reg_t idx, int v);
    script_row_t row;
    row        = '{idx: REG_MIN_PLAUSIBLE, default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = v;
    script.push_back(row);
  endfunction

  function automatic void add_reading(logic o, int mm, logic ok, int q);
    script_row_t row;
    row         = '{idx: REG_MIN_PLAUSIBLE, default: '0};
    row.rd.op   = o;
    row.rd.mm   = DW'(mm);
    row.rd.ok   = ok;
    row.rd.qual = QW'(q);
    script.push_back(row);
  endfunction

  function automatic void add_known(logic o, int mm, logic ok, int q, filtered_t w);
    add_reading(o, mm, ok, q);
    script[$].known = 1'b1;
    script[$].want  = w;
  endfunction

  task automatic report_miss(string msg);
    if (mismatches < 40) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want) report_miss($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Compare one accepted result beat against the oldest owed result.
  task automatic check_beat();
    filtered_t want;
    if (owed_results.size() == 0) begin
      report_miss("result beat with no reading outstanding");
      return;
    end
    want = owed_results.pop_front();
    check_field("distance_out", distance_out, want.mm);
    check_field("quality_echo", quality_echo, want.qual);
    check_field("plausible", plausible, want.plaus);
    check_field("quality_passed", quality_passed, want.qpass);
    check_field("quality_streak", quality_streak, want.qrun);
    check_field("agree_streak_out", agree_streak_out, want.arun);
    check_field("trusted", trusted, want.trusted);
    check_field("lowest_quality_out", lowest_quality_out, want.lowq);
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  // Write one register with the block idle; the pipeline is two deep, so it is
  // empty once the last owed result has come back.
  task automatic write_reg(cfg_reg_t idx, int v);
    logic [DW-1:0] bits;
    bits = DW'(v);
    settle();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bits;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_MIN_PLAUSIBLE: window_lo_mm    = bits;
      REG_MAX_PLAUSIBLE: window_hi_mm    = bits;
      REG_MIN_QUALITY:   quality_floor   = bits[QW-1:0];
      REG_CONSENSUS:     consensus_need  = bits[CW-1:0];
      REG_MAX_SPREAD:    spread_limit_mm = bits;
      default: ;
    endcase
  endtask

  // Offer one reading, hold it until accepted, then log what it owes.
  task automatic send_reading(reading_t rd, bit known, filtered_t want);
    filtered_t model;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= rd.op;
    distance_mm <= rd.mm;
    verdict_ok  <= rd.ok;
    sts_quality <= rd.qual;
    do @(posedge clk); while (!in_ready);
    model = predict_reading(rd);
    owed_results.push_back(known ? want : model);
  endtask

  // Receiver: check each accepted beat, then stall in random bursts unless the
  // run is in its quiet tail.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) check_beat();
      if (!quiet && stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 8);
      end else begin
        out_ready  <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    reading_t rd;
    int       lo_i;
    int       hi_i;
    int       q_i;
    int       c_i;
    int       s_i;
    int       anchor;
    int       pick;
    int       s;
    int       v;
    int       phase_len;
    int       rand_sent;

    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_MIN_PLAUSIBLE;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    op          <= OP_INGEST;
    distance_mm <= '0;
    verdict_ok  <= 1'b0;
    sts_quality <= '0;

    // Register defaults after reset.
    window_lo_mm    = '0;
    window_hi_mm    = MAX_PLAUSIBLE_RESET[DW-1:0];
    quality_floor   = '0;
    consensus_need  = CONSENSUS_RESET;
    spread_limit_mm = MAX_SPREAD_RESET[DW-1:0];
    clear_filter();

    // Directed script, defaults first: window 0..200000, floor 0,
    // consensus 3, spread 100.
    add_known(OP_CLEAR, MM_LO, 1'b1, -1, mk_out(0, 0, 0, 0, 0, 0, 0, 0));
    add_known(OP_INGEST, 1000, 1'b1, 50, mk_out(1000, 50, 1, 1, 1, 1, 0, 50));
    add_known(OP_INGEST, 1050, 1'b1, 40, mk_out(1050, 40, 1, 1, 2, 2, 0, 40));
    add_known(OP_INGEST, 1100, 1'b1, 60, mk_out(1100, 60, 1, 1, 3, 3, 1, 40));
    add_known(OP_INGEST, 1150, 1'b1, 70, mk_out(1150, 70, 1, 1, 3, 3, 1, 40));
    // Jump past the spread with a quality below the floor, then a bad verdict.
    add_reading(OP_INGEST, 1300, 1'b1, -5);
    add_reading(OP_INGEST, 1300, 1'b0, Q_HI);
    // Out of window on either side wipes the state.
    add_known(OP_INGEST, MM_HI, 1'b1, Q_LO, mk_out(MM_HI, Q_LO, 0, 0, 0, 0, 0, 0));
    add_known(OP_INGEST, MM_LO, 1'b1, Q_HI, mk_out(MM_LO, Q_HI, 0, 0, 0, 0, 0, 0));
    add_known(OP_INGEST, 200000, 1'b1, 0, mk_out(200000, 0, 1, 1, 1, 1, 0, 0));
    add_reading(OP_INGEST, 0, 1'b1, 0);
    add_known(OP_CLEAR, 12345, 1'b0, 777, mk_out(0, 0, 0, 0, 0, 0, 0, 0));
    // Widest window, zero consensus and zero spread: negatives clamp to zero,
    // trust is declared on every plausible reading.
    add_cfg(REG_MIN_PLAUSIBLE, MM_LO);
    add_cfg(REG_MAX_PLAUSIBLE, MM_HI);
    add_cfg(REG_MIN_QUALITY, Q_LO);
    add_cfg(REG_CONSENSUS, 0);
    add_cfg(REG_MAX_SPREAD, 0);
    add_known(OP_INGEST, MM_LO, 1'b0, Q_LO,
              mk_out(0, Q_LO, 1, 0, 0, 1, 1, Q_LO));
    add_reading(OP_INGEST, -5, 1'b1, Q_LO);
    add_reading(OP_INGEST, MM_HI, 1'b1, Q_HI);
    add_reading(OP_INGEST, MM_HI, 1'b1, 100);
    // Top consensus, full spread, top floor.
    add_cfg(REG_CONSENSUS, 255);
    add_cfg(REG_MAX_SPREAD, (1 << DW) - 1);
    add_cfg(REG_MIN_QUALITY, Q_HI);
    add_reading(OP_INGEST, 0, 1'b1, Q_HI);
    add_reading(OP_INGEST, MM_HI, 1'b1, Q_HI - 1);
    add_reading(OP_INGEST, -1, 1'b1, Q_HI);
    // Inverted window: nothing is plausible.
    add_cfg(REG_MIN_PLAUSIBLE, 100);
    add_cfg(REG_MAX_PLAUSIBLE, -100);
    add_known(OP_INGEST, 0, 1'b1, 5, mk_out(0, 5, 0, 0, 0, 0, 0, 0));
    add_known(OP_INGEST, 100, 1'b1, 5, mk_out(100, 5, 0, 0, 0, 0, 0, 0));
    add_known(OP_INGEST, -100, 1'b1, 5, mk_out(-100, 5, 0, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_reg(script[i].idx, script[i].val);
      else send_reading(script[i].rd, script[i].known, script[i].want);
    end

    // Random phases: each gets a fresh register set and its own idle mix.
    rand_sent = 0;
    while (rand_sent < RANDOM_READINGS) begin
      lo_i = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 2000)) - 1000 : rand_mm();
      hi_i = ($urandom_range(0, 9) < 7) ? fit_mm(lo_i + int'($urandom_range(500, 200000)))
                                        : rand_mm();
      q_i  = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 2000)) - 1000 : rand_q();
      pick = $urandom_range(0, 19);
      if (pick < 12)      c_i = $urandom_range(1, 6);
      else if (pick < 14) c_i = 0;
      else if (pick < 17) c_i = $urandom_range(7, 40);
      else                c_i = $urandom_range(0, 255);
      pick = $urandom_range(0, 19);
      if (pick < 12)      s_i = $urandom_range(0, 300);
      else if (pick < 17) s_i = $urandom_range(0, 5000);
      else                s_i = $urandom_range(0, (1 << DW) - 1);
      write_reg(REG_MIN_PLAUSIBLE, lo_i);
      write_reg(REG_MAX_PLAUSIBLE, hi_i);
      write_reg(REG_MIN_QUALITY, q_i);
      write_reg(REG_CONSENSUS, c_i);
      write_reg(REG_MAX_SPREAD, s_i);

      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      anchor    = (lo_i <= hi_i) ? lo_i + int'($urandom_range(0, hi_i - lo_i)) : 0;
      phase_len = $urandom_range(60, 220);

      for (int n = 0; n < phase_len && rand_sent < RANDOM_READINGS; n++) begin
        quiet   = (rand_sent >= RANDOM_READINGS - QUIET_TAIL);
        rd.op   = OP_INGEST;
        rd.ok   = ($urandom_range(0, 9) != 0);
        rd.qual = QW'(fit_q(int'(quality_floor) + int'($urandom_range(0, 300)) - 60));
        pick    = $urandom_range(0, 99);
        if (pick < 4) begin
          // Clear with junk in every other field.
          rd.op   = OP_CLEAR;
          rd.mm   = DW'(rand_mm());
          rd.ok   = 1'($urandom_range(0, 1));
          rd.qual = QW'(rand_q());
        end else if (pick < 12) begin
          // Aim just outside the window where there is room for it.
          if (hi_i < MM_HI && (lo_i == MM_LO || $urandom_range(0, 1)))
            v = hi_i + 1 + int'($urandom_range(0, MM_HI - 1 - hi_i));
          else if (lo_i > MM_LO)
            v = lo_i - 1 - int'($urandom_range(0, lo_i - 1 - MM_LO));
          else
            v = rand_mm();
          rd.mm = DW'(v);
        end else if (pick < 22) begin
          rd.mm   = DW'(rand_mm());
          rd.ok   = 1'($urandom_range(0, 1));
          rd.qual = QW'(rand_q());
        end else begin
          // Walk near the last reading, mostly inside the spread limit so
          // the streaks build up, now and then just beyond it.
          s = s_i;
          if (s > 20000) s = 20000;
          v = anchor + int'($urandom_range(0, 2 * (s + s / 8 + 1))) - (s + s / 8 + 1);
          if (lo_i <= hi_i) begin
            if (v < lo_i) v = lo_i;
            if (v > hi_i) v = hi_i;
          end
          v      = fit_mm(v);
          anchor = v;
          rd.mm  = DW'(v);
        end
        send_reading(rd, 1'b0, '{default: '0});
        rand_sent++;
        // Now and then hold the sender until the block has drained.
        if (!quiet && $urandom_range(0, 199) == 0) settle();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
